// ===== hw/rtl/keyed_subscriber_table_unit_defines.svh =====
// Assertion macros shared by the keyed subscriber table RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef KEYED_SUBSCRIBER_TABLE_UNIT_DEFINES_SVH
`define KEYED_SUBSCRIBER_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define KST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/kst_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the keyed subscriber table. No dependencies.
`timescale 1ns / 1ps

package kst_pkg;

    // Fixed field widths
    localparam int KEY_IN_W     = 64;
    localparam int KEY_IN_BYTES = KEY_IN_W / 8;
    localparam int ID_W         = 31;
    localparam int OP_W         = 2;
    localparam int ST_W         = 3;

    // Default sizes
    localparam int DEF_MAX_KEYS  = 16;
    localparam int DEF_MAX_SUBS  = 8;
    localparam int DEF_KEY_BYTES = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SUB   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNSUB = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP   = 3'd1;
    localparam logic [ST_W-1:0] ST_LFULL = 3'd2;
    localparam logic [ST_W-1:0] ST_TFULL = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTF  = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic            cap;           // capture the input item
        logic            kscan_clr;     // restart the key row scan
        logic            kscan_step;    // advance the key row scan
        logic            take_miss;     // point at the next free row, empty list
        logic            slot_clr;      // list slot index to zero
        logic            slot_inc;      // list slot index up by one
        logic            srd;           // read the current slot
        logic            shrd;          // read the slot after the current one
        logic            shwr;          // write read data to the current slot
        logic            append;        // append the subscriber, update row
        logic            kdec;          // shorten the row list by one
        logic            st_set;        // load the pending status
        logic [ST_W-1:0] st_val;
        logic            out_load;      // load the output register
        logic            out_from_slot; // output carries the slot id
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad;           // zero key, unused code, or zero id outside a query
        logic            kscan_done;
        logic            khit;
        logic            table_full;
        logic            len_zero;
        logic            list_full;
        logic            slot_end;      // slot index reached list length
        logic            slot_last;     // slot index is the final list entry
        logic            slot_match;    // slot read data holds the item id
        logic            out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/kst_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/kst_ctrl.sv =====
// Sequencing state machine of the keyed subscriber table.
// Depends on kst_pkg and keyed_subscriber_table_unit_defines.svh.
`timescale 1ns / 1ps
`include "keyed_subscriber_table_unit_defines.svh"

module kst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  kst_pkg::t_dp_stat  i_stat,
    output kst_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CHECK  = 11'b000_0000_0010,
        S_KSCAN  = 11'b000_0000_0100,
        S_DECIDE = 11'b000_0000_1000,
        S_SRD    = 11'b000_0001_0000,
        S_SCMP   = 11'b000_0010_0000,
        S_SHRD   = 11'b000_0100_0000,
        S_SHWR   = 11'b000_1000_0000,
        S_WRITE  = 11'b001_0000_0000,
        S_KDEC   = 11'b010_0000_0000,
        S_RESP   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.bad) begin
                    o_cmd.st_set = 1'b1;
                    o_cmd.st_val = kst_pkg::ST_NOTF;
                    n_state      = S_RESP;
                end else begin
                    o_cmd.kscan_clr = 1'b1;
                    n_state         = S_KSCAN;
                end
            end
            S_KSCAN: begin
                o_cmd.kscan_step = 1'b1;
                if (i_stat.kscan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_stat.op)
                    kst_pkg::OP_SUB: begin
                        if (i_stat.khit) begin
                            o_cmd.slot_clr = 1'b1;
                            n_state        = S_SRD;
                        end else if (i_stat.table_full) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = kst_pkg::ST_TFULL;
                            n_state      = S_RESP;
                        end else begin
                            o_cmd.take_miss = 1'b1;
                            n_state         = S_WRITE;
                        end
                    end
                    kst_pkg::OP_UNSUB: begin
                        if (i_stat.khit) begin
                            o_cmd.slot_clr = 1'b1;
                            n_state        = S_SRD;
                        end else begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = kst_pkg::ST_NOTF;
                            n_state      = S_RESP;
                        end
                    end
                    default: begin
                        if (!i_stat.khit) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = kst_pkg::ST_NOTF;
                            n_state      = S_RESP;
                        end else if (i_stat.len_zero) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = kst_pkg::ST_OK;
                            n_state      = S_RESP;
                        end else begin
                            o_cmd.slot_clr = 1'b1;
                            n_state        = S_SRD;
                        end
                    end
                endcase
            end
            S_SRD: begin
                if (i_stat.slot_end) begin
                    if (i_stat.op == kst_pkg::OP_SUB && !i_stat.list_full) begin
                        n_state = S_WRITE;
                    end else begin
                        o_cmd.st_set = 1'b1;
                        o_cmd.st_val = (i_stat.op == kst_pkg::OP_SUB) ?
                                       kst_pkg::ST_LFULL : kst_pkg::ST_NOTF;
                        n_state      = S_RESP;
                    end
                end else begin
                    o_cmd.srd = 1'b1;
                    n_state   = S_SCMP;
                end
            end
            S_SCMP: begin
                if (i_stat.op == kst_pkg::OP_QUERY) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load      = 1'b1;
                        o_cmd.out_from_slot = 1'b1;
                        if (i_stat.slot_last) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.slot_inc = 1'b1;
                            n_state        = S_SRD;
                        end
                    end
                end else if (i_stat.slot_match) begin
                    if (i_stat.op == kst_pkg::OP_SUB) begin
                        o_cmd.st_set = 1'b1;
                        o_cmd.st_val = kst_pkg::ST_DUP;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_SHRD;
                    end
                end else begin
                    o_cmd.slot_inc = 1'b1;
                    n_state        = S_SRD;
                end
            end
            S_SHRD: begin
                if (i_stat.slot_last) begin
                    n_state = S_KDEC;
                end else begin
                    o_cmd.shrd = 1'b1;
                    n_state    = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.shwr     = 1'b1;
                o_cmd.slot_inc = 1'b1;
                n_state        = S_SHRD;
            end
            S_WRITE: begin
                o_cmd.append = 1'b1;
                o_cmd.st_set = 1'b1;
                o_cmd.st_val = kst_pkg::ST_OK;
                n_state      = S_RESP;
            end
            S_KDEC: begin
                o_cmd.kdec   = 1'b1;
                o_cmd.st_set = 1'b1;
                o_cmd.st_val = kst_pkg::ST_OK;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `KST_ASSERT_NXT(a_idle_holds, r_state == S_IDLE && !i_s_tvalid, r_state == S_IDLE, "left idle without an item")
    `KST_ASSERT_IMP(a_load_free, o_cmd.out_load, i_stat.out_free, "output overwritten while held")
    `KST_ASSERT_IMP(a_append_sub, o_cmd.append, i_stat.op == kst_pkg::OP_SUB, "append outside subscribe")
    `KST_ASSERT_IMP(a_kdec_unsub, o_cmd.kdec, i_stat.op == kst_pkg::OP_UNSUB && i_stat.khit, "list shortened outside unsubscribe hit")

endmodule

// ===== hw/rtl/kst_dp.sv =====
// Datapath of the keyed subscriber table: item registers, key row memory,
// subscriber slot memory, scan counters and the output register.
// Depends on kst_pkg and kst_ram.
`timescale 1ns / 1ps

module kst_dp #(
    parameter int MAX_KEYS  = kst_pkg::DEF_MAX_KEYS,
    parameter int MAX_SUBS  = kst_pkg::DEF_MAX_SUBS,
    parameter int KEY_BYTES = kst_pkg::DEF_KEY_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kst_pkg::t_dp_cmd              i_cmd,
    output kst_pkg::t_dp_stat             o_stat,
    input  logic [kst_pkg::OP_W-1:0]      i_op,
    input  logic [kst_pkg::KEY_IN_W-1:0]  i_key,
    input  logic [kst_pkg::ID_W-1:0]      i_id,
    input  logic [kst_pkg::ID_W-1:0]      i_queue,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [kst_pkg::ST_W-1:0]      o_status,
    output logic [kst_pkg::ID_W-1:0]      o_found_id,
    output logic                          o_last
);

    localparam int ID_W    = kst_pkg::ID_W;
    localparam int KEY_W   = 8 * KEY_BYTES;
    localparam int LEN_W   = $clog2(MAX_SUBS + 1);
    localparam int KEY_AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int KCNT_W  = $clog2(MAX_KEYS + 1);
    localparam int SLOTS   = MAX_KEYS * MAX_SUBS;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KRAM_W  = KEY_W + LEN_W;
    localparam int SRAM_W  = 2 * ID_W;

    // Item registers
    logic [kst_pkg::OP_W-1:0] r_op;
    logic [KEY_W-1:0]         r_key;
    logic [ID_W-1:0]          r_id;
    logic [ID_W-1:0]          r_queue;
    logic [kst_pkg::ST_W-1:0] r_status;

    // Table and scan state
    logic [KCNT_W-1:0] r_count;
    logic [KCNT_W-1:0] r_krow;
    logic [KEY_AW-1:0] r_kcmp_row;
    logic              r_kv;
    logic              r_khit;
    logic              r_new;
    logic [KEY_AW-1:0] r_row;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_slot;

    // Output register
    logic                     r_out_valid;
    logic [kst_pkg::ST_W-1:0] r_out_status;
    logic [ID_W-1:0]          r_out_id;
    logic                     r_out_last;

    logic [kst_pkg::KEY_IN_W-1:0] w_norm;
    logic                         w_alive;

    logic              w_kram_re;
    logic              w_kram_we;
    logic [KRAM_W-1:0] w_kram_wdata;
    logic [KRAM_W-1:0] w_kram_rdata;
    logic [LEN_W-1:0]  w_len_new;
    logic              w_khit_now;

    logic [SLOT_AW-1:0] w_base;
    logic [SLOT_AW-1:0] w_addr_cur;
    logic [SLOT_AW-1:0] w_addr_nxt;
    logic [SLOT_AW-1:0] w_addr_app;
    logic               w_sram_re;
    logic               w_sram_we;
    logic [SLOT_AW-1:0] w_sram_raddr;
    logic [SLOT_AW-1:0] w_sram_waddr;
    logic [SRAM_W-1:0]  w_sram_wdata;
    logic [SRAM_W-1:0]  w_sram_rdata;
    logic               w_slot_last;
    logic               w_out_free;

    // Keep key bytes up to the first zero byte, within the key length
    always_comb begin
        w_alive = 1'b1;
        w_norm  = '0;
        for (int b = 0; b < kst_pkg::KEY_IN_BYTES; b++) begin
            if (b >= KEY_BYTES || i_key[8*b +: 8] == 8'd0) begin
                w_alive = 1'b0;
            end
            if (w_alive) begin
                w_norm[8*b +: 8] = i_key[8*b +: 8];
            end
        end
    end

    // Key row memory: {list length, key}
    assign w_kram_re    = i_cmd.kscan_step && (r_krow < r_count);
    assign w_kram_we    = i_cmd.append || i_cmd.kdec;
    assign w_len_new    = i_cmd.kdec ? (r_len - LEN_W'(1)) : (r_len + LEN_W'(1));
    assign w_kram_wdata = {w_len_new, r_key};
    assign w_khit_now   = r_kv && (w_kram_rdata[KEY_W-1:0] == r_key);

    kst_ram #(
        .WIDTH (KRAM_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_kram_we),
        .i_waddr (r_row),
        .i_wdata (w_kram_wdata),
        .i_re    (w_kram_re),
        .i_raddr (r_krow[KEY_AW-1:0]),
        .o_rdata (w_kram_rdata)
    );

    // Subscriber slot memory: {reply queue, id}
    assign w_base       = SLOT_AW'(r_row * MAX_SUBS);
    assign w_addr_cur   = w_base + SLOT_AW'(r_slot);
    assign w_addr_nxt   = w_addr_cur + SLOT_AW'(1);
    assign w_addr_app   = w_base + SLOT_AW'(r_len);
    assign w_sram_re    = i_cmd.srd || i_cmd.shrd;
    assign w_sram_raddr = i_cmd.shrd ? w_addr_nxt : w_addr_cur;
    assign w_sram_we    = i_cmd.append || i_cmd.shwr;
    assign w_sram_waddr = i_cmd.append ? w_addr_app : w_addr_cur;
    assign w_sram_wdata = i_cmd.append ? {r_queue, r_id} : w_sram_rdata;

    kst_ram #(
        .WIDTH (SRAM_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_sram_we),
        .i_waddr (w_sram_waddr),
        .i_wdata (w_sram_wdata),
        .i_re    (w_sram_re),
        .i_raddr (w_sram_raddr),
        .o_rdata (w_sram_rdata)
    );

    assign w_slot_last = ({1'b0, r_slot} + (LEN_W+1)'(1)) >= {1'b0, r_len};
    assign w_out_free  = !r_out_valid || i_m_tready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_krow      <= '0;
            r_kv        <= 1'b0;
            r_khit      <= 1'b0;
            r_new       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cap) begin
                r_new <= 1'b0;
            end
            if (i_cmd.kscan_clr) begin
                r_krow <= '0;
                r_kv   <= 1'b0;
                r_khit <= 1'b0;
            end else if (i_cmd.kscan_step) begin
                r_kv <= w_kram_re;
                if (w_kram_re) begin
                    r_krow <= r_krow + KCNT_W'(1);
                end
                if (w_khit_now) begin
                    r_khit <= 1'b1;
                end
            end
            if (i_cmd.take_miss) begin
                r_new <= 1'b1;
            end
            if (i_cmd.append && r_new) begin
                r_count <= r_count + KCNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op    <= i_op;
            r_key   <= w_norm[KEY_W-1:0];
            r_id    <= i_id;
            r_queue <= i_queue;
        end
        if (i_cmd.kscan_step && w_kram_re) begin
            r_kcmp_row <= r_krow[KEY_AW-1:0];
        end
        if (i_cmd.kscan_step && w_khit_now) begin
            r_row <= r_kcmp_row;
            r_len <= w_kram_rdata[KRAM_W-1:KEY_W];
        end else if (i_cmd.take_miss) begin
            r_row <= r_count[KEY_AW-1:0];
            r_len <= '0;
        end
        if (i_cmd.slot_clr) begin
            r_slot <= '0;
        end else if (i_cmd.slot_inc) begin
            r_slot <= r_slot + LEN_W'(1);
        end
        if (i_cmd.st_set) begin
            r_status <= i_cmd.st_val;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_from_slot ? kst_pkg::ST_OK : r_status;
            r_out_id     <= i_cmd.out_from_slot ? w_sram_rdata[ID_W-1:0] : '0;
            r_out_last   <= i_cmd.out_from_slot ? w_slot_last : 1'b1;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.bad        = (r_key == '0) || (r_op == kst_pkg::OP_RSVD) ||
                            ((r_op != kst_pkg::OP_QUERY) && (r_id == '0));
        o_stat.kscan_done = w_khit_now || (!r_kv && (r_krow == r_count));
        o_stat.khit       = r_khit;
        o_stat.table_full = (r_count == KCNT_W'(MAX_KEYS));
        o_stat.len_zero   = (r_len == '0);
        o_stat.list_full  = (r_len == LEN_W'(MAX_SUBS));
        o_stat.slot_end   = (r_slot == r_len);
        o_stat.slot_last  = w_slot_last;
        o_stat.slot_match = (w_sram_rdata[ID_W-1:0] == r_id);
        o_stat.out_free   = w_out_free;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_out_status;
    assign o_found_id = r_out_id;
    assign o_last     = r_out_last;

endmodule

// ===== hw/rtl/keyed_subscriber_table_unit.sv =====
// Per item, R key rows are compared (at most the rows in use) and L list slots are read
//   or shifted (at most MAX_SUBS); a query emits one result per slot, waiting on a held output.
// Items go one at a time; the one-port key row scan and the read-then-use slot step set the pace.
// Reset (i_rst_n low, synchronous): clears the controller, row fill count and output valid.
//   No clearing pass: rows above the fill count and slots above a row's list length are never read.
// Depends on kst_pkg, kst_ctrl, kst_dp and kst_ram.
`timescale 1ns / 1ps

module keyed_subscriber_table_unit #(
    parameter int MAX_KEYS  = kst_pkg::DEF_MAX_KEYS,
    parameter int MAX_SUBS  = kst_pkg::DEF_MAX_SUBS,
    parameter int KEY_BYTES = kst_pkg::DEF_KEY_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request channel
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // topic_key[63:0], sub_id[94:64], reply_queue[125:95], zero pad
    input  logic [1:0]   i_s_tuser,   // cmd[1:0]
    // Result channel
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [31:0]  o_m_tdata,   // found_id[30:0], zero pad
    output logic [2:0]   o_m_tuser,   // status[2:0]
    output logic         o_m_tlast    // final result of the item
);

    localparam int ID_W = kst_pkg::ID_W;
    localparam int KW   = kst_pkg::KEY_IN_W;

    kst_pkg::t_dp_cmd  w_cmd;
    kst_pkg::t_dp_stat w_stat;
    logic [ID_W-1:0]   w_found_id;

    // The controller only takes an item while idle; the datapath captures it
    // on the same edge and holds it through the scan.
    kst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Results wait in the datapath output register; the controller loads a
    // new one only when that register is empty or being drained.
    kst_dp #(
        .MAX_KEYS  (MAX_KEYS),
        .MAX_SUBS  (MAX_SUBS),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_op       (i_s_tuser),
        .i_key      (i_s_tdata[KW-1:0]),
        .i_id       (i_s_tdata[KW +: ID_W]),
        .i_queue    (i_s_tdata[KW+ID_W +: ID_W]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_status   (o_m_tuser),
        .o_found_id (w_found_id),
        .o_last     (o_m_tlast)
    );

    // Pad the id out to a whole number of bytes
    assign o_m_tdata = {1'b0, w_found_id};

endmodule
